>>> hw/rtl/owht_pkg.sv
// Shared types and constants for the orthogonal wire hit test unit.
// Holds the transaction payload structs and the controller/datapath command
// and status bundles. Depends on nothing.
package owht_pkg;

	localparam int COORD_BITS = 16;
	localparam int DIST_BITS  = COORD_BITS + 1;
	localparam int TOL_BITS   = 16;
	localparam int SQ_BITS    = 2 * COORD_BITS;
	localparam int SUM_BITS   = SQ_BITS + 1;
	localparam int RAD_BITS   = 2 * DIST_BITS;
	localparam int REM_BITS   = DIST_BITS + 1;
	localparam int ROOT_STEPS = DIST_BITS;
	localparam int ITER_BITS  = $clog2(ROOT_STEPS);

	localparam logic [TOL_BITS-1:0] TOL_RESET = TOL_BITS'(64);

	localparam logic FUNC_SET_PATH = 1'b0;
	localparam logic FUNC_QUERY    = 1'b1;

	typedef logic signed [COORD_BITS-1:0] coord_t;

	typedef struct packed {
		logic   func;
		coord_t from_x;
		coord_t from_y;
		coord_t to_x;
		coord_t to_y;
		coord_t point_x;
		coord_t point_y;
	} in_item_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] nearest_distance;
		logic                 on_wire;
		logic                 path_present;
	} out_item_t;

	typedef struct packed {
		logic cap_path;
		logic cap_point;
		logic geom;
		logic sq1;
		logic sq2;
		logic sum;
		logic next_leg;
		logic root_init;
		logic root_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic path_valid;
		logic route_bent;
		logic second_leg;
		logic root_last;
		logic out_free;
	} dp_status_t;

endpackage

>>> hw/rtl/owht_ctrl.sv
// Controller state machine of the orthogonal wire hit test unit.
// Sequences leg measurement, squaring, the square root and the result hand-off.
// Depends on owht_pkg.
module owht_ctrl
	import owht_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_func,
	output logic       in_ready,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE      = 8'b0000_0001,
		ST_GEOM      = 8'b0000_0010,
		ST_SQ1       = 8'b0000_0100,
		ST_SQ2       = 8'b0000_1000,
		ST_SUM       = 8'b0001_0000,
		ST_ROOT_INIT = 8'b0010_0000,
		ST_ROOT      = 8'b0100_0000,
		ST_DONE      = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (in_func == FUNC_SET_PATH) begin
						cmd.cap_path = 1'b1;
					end else begin
						cmd.cap_point = 1'b1;
						// Without a stored path the result is fixed, so skip the math.
						state_d = status.path_valid ? ST_GEOM : ST_DONE;
					end
				end
			end
			ST_GEOM: begin
				cmd.geom = 1'b1;
				state_d  = ST_SQ1;
			end
			ST_SQ1: begin
				cmd.sq1 = 1'b1;
				state_d = ST_SQ2;
			end
			ST_SQ2: begin
				cmd.sq2 = 1'b1;
				state_d = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				if (status.route_bent && !status.second_leg) begin
					cmd.next_leg = 1'b1;
					state_d      = ST_GEOM;
				end else begin
					state_d = ST_ROOT_INIT;
				end
			end
			ST_ROOT_INIT: begin
				cmd.root_init = 1'b1;
				state_d       = ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (status.root_last) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> hw/rtl/owht_datapath.sv
// Datapath of the orthogonal wire hit test unit: path and tolerance registers,
// leg geometry, a shared squaring multiplier, a bit-serial square root and the
// output register. Depends on owht_pkg.
module owht_datapath
	import owht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  in_item_t            in_data,
	input  logic                cfg_wr_en,
	input  logic [TOL_BITS-1:0] cfg_wr_data,
	input  dp_cmd_t             cmd,
	output dp_status_t          status,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data
);

	coord_t start_x_q, start_y_q, end_x_q, end_y_q;
	logic   route_bent_q;
	logic   path_valid_q;
	logic [TOL_BITS-1:0] tol_q;

	coord_t point_x_q, point_y_q;
	logic   leg_q;

	logic [COORD_BITS-1:0] d1_q, d2_q;
	logic [SQ_BITS-1:0]    sq_q, part_q;
	logic [SUM_BITS-1:0]   best_q;

	logic [RAD_BITS-1:0]   rad_q;
	logic [REM_BITS-1:0]   rem_q;
	logic [DIST_BITS-1:0]  root_q;
	logic [ITER_BITS-1:0]  iter_q;

	logic      out_valid_q;
	out_item_t out_q;

	logic   leg_vert;
	coord_t seg_a, seg_b, seg_c;
	coord_t seg_lo, seg_hi, along, across, clamped;
	logic [COORD_BITS-1:0] d1_d, d2_d;
	logic [COORD_BITS-1:0] sq_src;
	logic [SQ_BITS-1:0]    sq_d;
	logic [SUM_BITS-1:0]   total;
	logic [REM_BITS+1:0]   rem_sh, trial;

	function automatic logic [COORD_BITS-1:0] abs_diff(coord_t a, coord_t b);
		logic signed [COORD_BITS:0] diff;
		logic signed [COORD_BITS:0] mag;
		diff = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
		mag  = diff[COORD_BITS] ? -diff : diff;
		return mag[COORD_BITS-1:0];
	endfunction

	// The first leg is horizontal unless the path is a straight vertical wire.
	// The second leg of an L route is always the vertical one through the corner.
	assign leg_vert = leg_q || (!route_bent_q && (start_x_q == end_x_q));

	always_comb begin
		if (leg_vert) begin
			seg_a  = start_y_q;
			seg_b  = end_y_q;
			seg_c  = leg_q ? end_x_q : start_x_q;
			along  = point_y_q;
			across = point_x_q;
		end else begin
			seg_a  = start_x_q;
			seg_b  = end_x_q;
			seg_c  = start_y_q;
			along  = point_x_q;
			across = point_y_q;
		end
		seg_lo = (seg_a < seg_b) ? seg_a : seg_b;
		seg_hi = (seg_a < seg_b) ? seg_b : seg_a;
		if (along < seg_lo) begin
			clamped = seg_lo;
		end else if (along > seg_hi) begin
			clamped = seg_hi;
		end else begin
			clamped = along;
		end
		d1_d = abs_diff(along, clamped);
		d2_d = abs_diff(across, seg_c);
	end

	assign sq_src = cmd.sq1 ? d1_q : d2_q;
	assign sq_d   = sq_src * sq_src;
	assign total  = {1'b0, part_q} + {1'b0, sq_q};

	assign rem_sh = {rem_q, rad_q[RAD_BITS-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q    <= '0;
			start_y_q    <= '0;
			end_x_q      <= '0;
			end_y_q      <= '0;
			route_bent_q <= 1'b0;
			path_valid_q <= 1'b0;
			tol_q        <= TOL_RESET;
		end else begin
			if (cfg_wr_en) begin
				tol_q <= cfg_wr_data;
			end
			if (cmd.cap_path) begin
				start_x_q    <= in_data.from_x;
				start_y_q    <= in_data.from_y;
				end_x_q      <= in_data.to_x;
				end_y_q      <= in_data.to_y;
				route_bent_q <= (in_data.from_x != in_data.to_x) &&
				                (in_data.from_y != in_data.to_y);
				path_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_point) begin
			point_x_q <= in_data.point_x;
			point_y_q <= in_data.point_y;
			leg_q     <= 1'b0;
		end else if (cmd.next_leg) begin
			leg_q <= 1'b1;
		end
		if (cmd.geom) begin
			d1_q <= d1_d;
			d2_q <= d2_d;
		end
		if (cmd.sq1) begin
			sq_q <= sq_d;
		end
		if (cmd.sq2) begin
			sq_q   <= sq_d;
			part_q <= sq_q;
		end
		if (cmd.sum) begin
			if (!leg_q || (total < best_q)) begin
				best_q <= total;
			end
		end
		if (cmd.root_init) begin
			rad_q  <= {{(RAD_BITS-SUM_BITS){1'b0}}, best_q};
			rem_q  <= '0;
			root_q <= '0;
			iter_q <= '0;
		end else if (cmd.root_step) begin
			rad_q  <= {rad_q[RAD_BITS-3:0], 2'b00};
			iter_q <= iter_q + ITER_BITS'(1);
			if (rem_sh >= trial) begin
				rem_q  <= REM_BITS'(rem_sh - trial);
				root_q <= {root_q[DIST_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[REM_BITS-1:0];
				root_q <= {root_q[DIST_BITS-2:0], 1'b0};
			end
		end
		if (cmd.load_out) begin
			if (path_valid_q) begin
				out_q.nearest_distance <= root_q;
				out_q.on_wire          <= (root_q <= {1'b0, tol_q});
				out_q.path_present     <= 1'b1;
			end else begin
				out_q.nearest_distance <= '1;
				out_q.on_wire          <= 1'b0;
				out_q.path_present     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign status.path_valid = path_valid_q;
	assign status.route_bent = route_bent_q;
	assign status.second_leg = leg_q;
	assign status.root_last  = (iter_q == ITER_BITS'(ROOT_STEPS - 1));
	assign status.out_free   = !out_valid_q || out_ready;

endmodule

>>> hw/rtl/orthogonal_wire_hit_test_unit.sv
// Top level of the orthogonal wire hit test unit.
// Joins the controller (owht_ctrl) and the datapath (owht_datapath); uses owht_pkg.
//
// A set-path transaction (func 0) stores the wire ends and gives no result. A query
// transaction (func 1) works through each leg in turn (geometry, a first and a second
// squaring on the shared multiplier, and the sum), then loads the square root, runs
// the bit-serial root (one result bit per cycle) and loads the output register. The
// next transaction is accepted only once that result has been loaded. A query with
// no stored path skips the math and goes straight to loading its all-ones result.
// The load waits while the output register still holds a result that the receiver
// has not taken, and the input stays closed for that time.
module orthogonal_wire_hit_test_unit
	import owht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  in_item_t            in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [TOL_BITS-1:0] cfg_wr_data
);

	dp_cmd_t    cmd;
	dp_status_t status;

	owht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_func  (in_data.func),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	owht_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

>>> verif/owht_hit_checker.sv
// Scoreboard for the orthogonal wire hit test unit: predicts every query result
// from the accepted transactions and compares it with the output channel.
// Depends on owht_pkg for the payload structs and field widths.
module owht_hit_checker
	import owht_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  in_item_t            in_data,
	input  logic                out_valid,
	input  logic                out_ready,
	input  out_item_t           out_data,
	input  logic                cfg_wr_en,
	input  logic [TOL_BITS-1:0] cfg_wr_data,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the stored wire and the tolerance register.
	longint              wire_sx, wire_sy, wire_ex, wire_ey;
	bit                  wire_bent;
	bit                  wire_set;
	logic [TOL_BITS-1:0] tol_shadow;

	out_item_t           hit_q[$];

	// Squared distance from a point to an axis-aligned leg with fixed coordinate c
	// running from a to b along the other axis.
	function automatic longint leg_dist_sq(longint px, longint py, longint a, longint b,
			longint c, bit horiz);
		longint lo, hi, along, across, clamped, d_along, d_across;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		along = horiz ? px : py;
		across = horiz ? py : px;
		clamped = (along < lo) ? lo : ((along > hi) ? hi : along);
		d_along = along - clamped;
		d_across = across - c;
		return d_along * d_along + d_across * d_across;
	endfunction

	function automatic logic [DIST_BITS-1:0] floor_root(longint sq);
		longint rem, root, trial;
		rem = 0;
		root = 0;
		for (int p = 31; p >= 0; p--) begin
			rem = (rem << 2) | ((sq >> (2 * p)) & 3);
			trial = (root << 2) | 1;
			if (rem >= trial) begin
				rem = rem - trial;
				root = (root << 1) | 1;
			end else begin
				root = root << 1;
			end
		end
		return root[DIST_BITS-1:0];
	endfunction

	function automatic out_item_t predict_hit(coord_t qx, coord_t qy);
		out_item_t res;
		longint    px, py, best, leg2;
		if (!wire_set) begin
			res.nearest_distance = '1;
			res.on_wire = 1'b0;
			res.path_present = 1'b0;
			return res;
		end
		px = longint'(qx);
		py = longint'(qy);
		if (wire_bent) begin
			// Horizontal leg to the corner, then the vertical leg to the end.
			best = leg_dist_sq(px, py, wire_sx, wire_ex, wire_sy, 1'b1);
			leg2 = leg_dist_sq(px, py, wire_sy, wire_ey, wire_ex, 1'b0);
			if (leg2 < best)
				best = leg2;
		end else if (wire_sx == wire_ex) begin
			best = leg_dist_sq(px, py, wire_sy, wire_ey, wire_sx, 1'b0);
		end else begin
			best = leg_dist_sq(px, py, wire_sx, wire_ex, wire_sy, 1'b1);
		end
		res.nearest_distance = floor_root(best);
		res.on_wire = (DIST_BITS'(tol_shadow) >= res.nearest_distance);
		res.path_present = 1'b1;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		int        errs;
		errs = 0;
		if (!arst_n) begin
			wire_sx <= 0;
			wire_sy <= 0;
			wire_ex <= 0;
			wire_ey <= 0;
			wire_bent <= 1'b0;
			wire_set <= 1'b0;
			tol_shadow <= TOL_RESET;
			hit_q.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en)
				tol_shadow <= cfg_wr_data;
			if (out_valid && out_ready) begin
				if (hit_q.size() == 0) begin
					$error("result transaction with no query outstanding: %p", out_data);
					errs++;
				end else begin
					want = hit_q.pop_front();
					if (out_data.nearest_distance !== want.nearest_distance) begin
						$error("nearest_distance: expected %0d, got %0d",
							want.nearest_distance, out_data.nearest_distance);
						errs++;
					end
					if (out_data.on_wire !== want.on_wire) begin
						$error("on_wire: expected %0b, got %0b", want.on_wire, out_data.on_wire);
						errs++;
					end
					if (out_data.path_present !== want.path_present) begin
						$error("path_present: expected %0b, got %0b",
							want.path_present, out_data.path_present);
						errs++;
					end
				end
			end
			if (in_valid && in_ready) begin
				if (in_data.func == FUNC_SET_PATH) begin
					wire_sx <= longint'(in_data.from_x);
					wire_sy <= longint'(in_data.from_y);
					wire_ex <= longint'(in_data.to_x);
					wire_ey <= longint'(in_data.to_y);
					wire_bent <= (in_data.from_x != in_data.to_x)
						&& (in_data.from_y != in_data.to_y);
					wire_set <= 1'b1;
				end else begin
					hit_q.insert(hit_q.size(), predict_hit(in_data.point_x, in_data.point_y));
				end
			end
			fail_count <= fail_count + errs;
			pending <= hit_q.size();
		end
	end

endmodule

>>> verif/orthogonal_wire_hit_test_unit_tb.sv
// Testbench top for the orthogonal wire hit test unit: clock, reset, stimulus,
// receiver stalls and the final verdict. Depends on owht_pkg, the unit itself
// and the owht_hit_checker scoreboard.
module orthogonal_wire_hit_test_unit_tb;
	import owht_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	in_item_t            in_data = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_item_t           out_data;
	logic                cfg_wr_en = 1'b0;
	logic [TOL_BITS-1:0] cfg_wr_data = '0;
	int                  fail_count;
	int                  pending;

	// Stimulus bookkeeping: the wire last sent, used to aim queries near it.
	int                  aim_fx, aim_fy, aim_tx, aim_ty;
	int                  cur_tol = int'(TOL_RESET);
	int                  burst_left = 0;
	int                  n_paths = 0;
	int                  n_queries = 0;
	int                  n_tols = 1;

	orthogonal_wire_hit_test_unit u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	owht_hit_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("status: fail");
		$finish;
	end

	// The receiver switches between always ready, coin flips, a rotating mask
	// and a mode in which it is mostly stalled.
	initial begin
		int          mode, len;
		logic [31:0] mask;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(16, 200);
			mask = $urandom;
			for (int i = 0; i < len; i++) begin
				@(posedge clk);
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					2: out_ready <= mask[i % 32];
					default: out_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	function automatic coord_t clamp_coord(int v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	function automatic coord_t any_coord();
		case ($urandom_range(0, 9))
			0: return coord_t'(-32768);
			1: return coord_t'(32767);
			2: return coord_t'(0);
			3, 4, 5: return coord_t'($urandom);
			default: return clamp_coord(int'($urandom_range(0, 2047)) - 1024);
		endcase
	endfunction

	// Holds valid through a burst; each burst opens with a gap in which valid is low.
	task automatic push_item(input in_item_t item);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 40);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
		end
		in_data <= item;
		in_valid <= 1'b1;
		do
			@(posedge clk);
		while (!in_ready);
		burst_left--;
	endtask

	task automatic send_set(input coord_t fx, input coord_t fy, input coord_t tx,
			input coord_t ty);
		in_item_t item;
		item.func = FUNC_SET_PATH;
		item.from_x = fx;
		item.from_y = fy;
		item.to_x = tx;
		item.to_y = ty;
		item.point_x = coord_t'($urandom);
		item.point_y = coord_t'($urandom);
		aim_fx = int'(fx);
		aim_fy = int'(fy);
		aim_tx = int'(tx);
		aim_ty = int'(ty);
		n_paths++;
		push_item(item);
	endtask

	task automatic send_query(input coord_t px, input coord_t py);
		in_item_t item;
		item.func = FUNC_QUERY;
		item.from_x = coord_t'($urandom);
		item.from_y = coord_t'($urandom);
		item.to_x = coord_t'($urandom);
		item.to_y = coord_t'($urandom);
		item.point_x = px;
		item.point_y = py;
		n_queries++;
		push_item(item);
	endtask

	// A wire of a random shape: horizontal, vertical, a single point, or an L.
	task automatic send_random_path();
		coord_t fx, fy, tx, ty;
		fx = any_coord();
		fy = any_coord();
		tx = any_coord();
		ty = any_coord();
		case ($urandom_range(0, 5))
			0: ty = fy;
			1: tx = fx;
			2: begin
				tx = fx;
				ty = fy;
			end
			default: ;
		endcase
		send_set(fx, fy, tx, ty);
	endtask

	// A point close to one of the two legs, with an offset scaled to the tolerance
	// so that both hit and miss come up.
	task automatic send_near_query();
		int span, along, across, lo, hi, fixed_c;
		bit horiz;
		span = 2 * cur_tol + 8;
		if (span > 4096)
			span = 4096;
		horiz = 1'($urandom_range(0, 1));
		if (horiz) begin
			lo = (aim_fx < aim_tx) ? aim_fx : aim_tx;
			hi = (aim_fx < aim_tx) ? aim_tx : aim_fx;
			fixed_c = aim_fy;
		end else begin
			lo = (aim_fy < aim_ty) ? aim_fy : aim_ty;
			hi = (aim_fy < aim_ty) ? aim_ty : aim_fy;
			fixed_c = aim_tx;
		end
		along = lo + int'($urandom_range(0, hi - lo + 128)) - 64;
		across = fixed_c + int'($urandom_range(0, 2 * span)) - span;
		if (horiz)
			send_query(clamp_coord(along), clamp_coord(across));
		else
			send_query(clamp_coord(across), clamp_coord(along));
	endtask

	// Lets the unit drain completely before the tolerance register changes.
	// A clock edge passes first so that a transaction accepted just now is counted.
	task automatic write_tolerance(input int tol);
		if (burst_left != 0 || in_valid)
			in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		cfg_wr_data <= TOL_BITS'(tol);
		cfg_wr_en <= 1'b1;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		cur_tol = tol;
		n_tols++;
	endtask

	task automatic run_random(input int quota);
		int sent, nq;
		sent = 0;
		while (sent < quota) begin
			send_random_path();
			sent++;
			nq = $urandom_range(1, 8);
			for (int i = 0; i < nq; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_query(coord_t'($urandom), coord_t'($urandom));
				else
					send_near_query();
				sent++;
			end
		end
	endtask

	initial begin
		int tol_plan[6];
		tol_plan = '{0, 65535, 1, 0, 0, 64};
		tol_plan[3] = $urandom_range(0, 65535);
		tol_plan[4] = $urandom_range(2, 200);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries before any wire exists.
		send_query(coord_t'(0), coord_t'(0));
		send_query(coord_t'(-32768), coord_t'(32767));
		// Full-width horizontal wire, with hits on the tolerance boundary.
		send_set(coord_t'(-32768), coord_t'(0), coord_t'(32767), coord_t'(0));
		send_query(coord_t'(0), coord_t'(64));
		send_query(coord_t'(0), coord_t'(65));
		send_query(coord_t'(0), coord_t'(-64));
		send_query(coord_t'(32767), coord_t'(-32768));
		// Full-height vertical wire.
		send_set(coord_t'(5), coord_t'(32767), coord_t'(5), coord_t'(-32768));
		send_query(coord_t'(5), coord_t'(100));
		send_query(coord_t'(-32768), coord_t'(-32768));
		// A wire of zero length, including the farthest possible point.
		send_set(coord_t'(32767), coord_t'(32767), coord_t'(32767), coord_t'(32767));
		send_query(coord_t'(32767), coord_t'(32767));
		send_query(coord_t'(-32768), coord_t'(-32768));
		send_query(coord_t'(32767), coord_t'(32703));
		// L routes in both directions: beyond each end, at the corner and inside.
		send_set(coord_t'(-100), coord_t'(-200), coord_t'(300), coord_t'(400));
		send_query(coord_t'(300), coord_t'(-200));
		send_query(coord_t'(250), coord_t'(-150));
		send_query(coord_t'(-150), coord_t'(-200));
		send_query(coord_t'(300), coord_t'(450));
		send_query(coord_t'(400), coord_t'(-300));
		send_set(coord_t'(300), coord_t'(400), coord_t'(-100), coord_t'(-200));
		send_query(coord_t'(300), coord_t'(-200));
		send_query(coord_t'(-100), coord_t'(400));
		send_query(coord_t'(0), coord_t'(0));

		foreach (tol_plan[k]) begin
			write_tolerance(tol_plan[k]);
			run_random(120);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		$display("Covered %0d transactions: %0d wire updates and %0d queries",
			n_paths + n_queries, n_paths, n_queries);
		$display("across %0d tolerance settings, reset value and both extremes included.",
			n_tols);
		if (pending != 0)
			$error("%0d query results never arrived", pending);
		if (fail_count == 0 && pending == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/owht_pkg.sv
hw/rtl/owht_ctrl.sv
hw/rtl/owht_datapath.sv
hw/rtl/orthogonal_wire_hit_test_unit.sv
verif/owht_hit_checker.sv
verif/orthogonal_wire_hit_test_unit_tb.sv
